/* hdl/ics_pkg.sv */
// ics_pkg: shared constants and the item record that travels along the
// compare chain of the inversion counter. No dependencies.
package ics_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 11;
  localparam int GT_W      = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // One element in flight through the chain
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    placed;   // already written into a free cell
    logic [GT_W-1:0]         greater;  // stored elements seen that exceed value
  } item_t;

endpackage

/* hdl/ics_cell.sv */
// ics_cell: one slot of the inversion chain. Holds one stored element,
// compares it with the passing item and hands the item on.
// Depends on ics_pkg.
module ics_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  ics_pkg::item_t in_item,
  output ics_pkg::item_t out_item
);

  logic                             slot_valid;
  logic signed [ics_pkg::VAL_W-1:0] slot_value;
  ics_pkg::item_t                   item_next;
  logic                             take;

  assign take = in_item.valid && !slot_valid && !in_item.placed;

  always_comb begin
    item_next = in_item;
    if (slot_valid && (slot_value > in_item.value)) begin
      item_next.greater = in_item.greater + ics_pkg::GT_W'(1);
    end
    if (!slot_valid) begin
      item_next.placed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= 1'b0;
      out_item.valid <= 1'b0;
    end else if (advance) begin
      out_item <= item_next;
      if (in_item.valid) begin
        // the last item of an array empties every slot it passes
        if (in_item.last) begin
          slot_valid <= 1'b0;
        end else if (take) begin
          slot_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      slot_value <= in_item.value;
    end
  end

endmodule

/* hdl/ics_tail.sv */
// ics_tail: end of the chain. Keeps the saturating running total and the
// sticky drop flag, and holds the result register. Depends on ics_pkg.
module ics_tail (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  ics_pkg::item_t            in_item,
  output logic                      res_valid,
  output logic [ics_pkg::CNT_W-1:0] res_count,
  output logic                      res_done,
  output logic                      res_ovf
);

  logic [ics_pkg::CNT_W-1:0] total;
  logic [ics_pkg::CNT_W-1:0] total_next;
  logic                      ovf_seen;
  logic                      ovf_next;
  logic [ics_pkg::CNT_W:0]   sum;

  assign sum = {1'b0, total} + (ics_pkg::CNT_W + 1)'(in_item.greater);

  always_comb begin
    total_next = total;
    ovf_next   = ovf_seen;
    if (in_item.placed) begin
      total_next = sum[ics_pkg::CNT_W] ? ics_pkg::COUNT_MAX : sum[ics_pkg::CNT_W-1:0];
    end else begin
      // no free slot was found: element dropped
      ovf_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      ovf_seen  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_item.valid;
      if (in_item.valid) begin
        total    <= in_item.last ? '0 : total_next;
        ovf_seen <= in_item.last ? 1'b0 : ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.valid) begin
      res_count <= total_next;
      res_done  <= in_item.last;
      res_ovf   <= ovf_next;
    end
  end

endmodule

/* hdl/inversion_count_stream_top.sv */
// Streaming inversion counter: takes one array element per item and returns
// one result per item with the running count of inversions in its array so
// far (each element adds the earlier elements strictly greater than it).
// Elements travel along a row of MAX_ITEMS compare cells, one cell per cycle
// unless stalled, each cell holding one stored element; a new item can be
// accepted every cycle unless stalled. The first cell captures an item at the
// edge that accepts it, and the item then passes the other cells and the
// result register. The whole row stalls while a result waits on m_tready.
// An element arriving with all cells full is dropped and flagged until the
// end of its array. Depends on ics_pkg, ics_cell and ics_tail.
module inversion_count_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] running_count, [15:11] zero
  output logic        m_tlast,   // done_res
  output logic        m_tuser    // overflow
);

  ics_pkg::item_t            links [ics_pkg::MAX_ITEMS+1];
  logic                      advance;
  logic [ics_pkg::CNT_W-1:0] res_count;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_comb begin
    links[0]         = '0;
    links[0].valid   = s_tvalid;
    links[0].value   = s_tdata;
    links[0].last    = s_tlast;
  end

  for (genvar k = 0; k < ics_pkg::MAX_ITEMS; k++) begin : g_cell
    ics_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_item  (links[k]),
      .out_item (links[k+1])
    );
  end

  ics_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_item   (links[ics_pkg::MAX_ITEMS]),
    .res_valid (m_tvalid),
    .res_count (res_count),
    .res_done  (m_tlast),
    .res_ovf   (m_tuser)
  );

  assign m_tdata = {(16 - ics_pkg::CNT_W)'(0), res_count};

endmodule

/* hdl/ics_checker.sv */
// ics_checker: port-level checks for inversion_count_stream_top, attached
// by the bind below. Depends on nothing but the top level's ports.
module ics_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output space");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_count_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:11] == 5'd0)
    else $error("padding bits of result set");

endmodule

bind inversion_count_stream_top ics_checker u_ics_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
